### design/eds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_pkg
// shared types and constants of the event deadline scheduler
// ----------------------------------------------------------------------------
package eds_pkg;

	localparam logic [31:0] FRAME_RESET = 32'd17556;

	// command codes of an item
	localparam logic [3:0] MODE_SCHED_REL = 4'd0;
	localparam logic [3:0] MODE_SCHED_ABS = 4'd1;
	localparam logic [3:0] MODE_REMOVE    = 4'd2;
	localparam logic [3:0] MODE_CLEAR_GRP = 4'd3;
	localparam logic [3:0] MODE_RESCHED   = 4'd4;
	localparam logic [3:0] MODE_SPEED     = 4'd5;
	localparam logic [3:0] MODE_ADVANCE   = 4'd6;
	localparam logic [3:0] MODE_POP       = 4'd7;
	localparam logic [3:0] MODE_FRAME     = 4'd8;

	typedef struct packed {
		logic [3:0]  mode;
		logic [3:0]  slot_id;
		logic [31:0] amount;
		logic        double_speed_request;
	} item_t;

	typedef struct packed {
		logic        event_valid;
		logic [3:0]  fired_id;
		logic [31:0] fired_cycle;
		logic [31:0] current_time;
		logic        any_pending;
		logic        frame_over;
	} result_t;

	// operation broadcast to every cell of the row
	typedef enum logic [2:0] {
		OP_NOP,
		OP_WRITE,
		OP_CLEAR,
		OP_CLEAR_GROUP,
		OP_SPEED_UP,
		OP_SPEED_DOWN,
		OP_FRAME
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [3:0]  id;
		logic [31:0] value;
		logic [31:0] rel;
		logic        set_rel;
		logic [31:0] frame_len;
	} cell_cmd_t;

endpackage

### design/eds_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_cell
// one event slot: deadline, relative delay, scheduled bit, and one stage of
// the earliest-deadline scan chain
// ----------------------------------------------------------------------------
module eds_cell import eds_pkg::*; #(
	parameter int INDEX = 0,
	parameter int SCALED_EVENTS = 4,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic             in_valid,
	input  logic [IDX_W-1:0] in_idx,
	input  logic [31:0]      in_dl,
	output logic             out_valid,
	output logic [IDX_W-1:0] out_idx,
	output logic [31:0]      out_dl,
	output logic             sched
);

	localparam bit SCALED = (INDEX < SCALED_EVENTS);

	logic        sched_q;
	logic [31:0] dl_q;
	logic [31:0] rel_q;
	logic        hit;
	logic        keep;

	assign hit   = ({28'd0, cmd.id} == 32'(INDEX));
	assign sched = sched_q;
	// strictly smaller wins, so ties stay with the lower id upstream
	assign keep  = sched_q && (!in_valid || (dl_q < in_dl));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= keep || in_valid;
			case (cmd.op)
				OP_WRITE: begin
					if (hit) sched_q <= 1'b1;
				end
				OP_CLEAR: begin
					if (hit) sched_q <= 1'b0;
				end
				OP_CLEAR_GROUP: begin
					if (SCALED) sched_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		out_idx <= keep ? IDX_W'(INDEX) : in_idx;
		out_dl  <= keep ? dl_q : in_dl;
		case (cmd.op)
			OP_WRITE: begin
				if (hit) begin
					dl_q <= cmd.value;
					if (cmd.set_rel) rel_q <= cmd.rel;
				end
			end
			OP_SPEED_UP: begin
				if (SCALED && sched_q) dl_q <= dl_q + rel_q;
			end
			OP_SPEED_DOWN: begin
				if (SCALED && sched_q) dl_q <= dl_q - rel_q;
			end
			OP_FRAME: begin
				if (sched_q && (dl_q > cmd.frame_len)) dl_q <= dl_q - cmd.frame_len;
			end
			default: begin
			end
		endcase
	end

endmodule

### design/event_deadline_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_deadline_scheduler_unit
// earliest-deadline event slot scheduler built as a row of slot cells
// ----------------------------------------------------------------------------
// Commands are taken one at a time: start is accepted when busy is low, and
// exactly one result follows, shown for a single cycle with done high. The
// receiver cannot stall, so sample result whenever done is high. A command
// that needs no search (advance, no-op, pop with nothing pending, remove of a
// slot other than the earliest, a slot id out of range) passes from the
// execute state straight to the finish state; a schedule that leaves the
// earliest slot in place goes through the placement state between them. A
// command that rescans the slots (remove of the earliest slot, clear group,
// speed change, pop, frame turnaround, or rescheduling the earliest slot)
// adds the scan, in which the running minimum walks one cell per cycle down
// the row of slot cells, and the take state; a reschedule of the earliest
// slot then also goes through the placement state.
// frame_length must be written over the APB-style port only while no command
// is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module event_deadline_scheduler_unit import eds_pkg::*; #(
	parameter int NUM_EVENTS = 12,
	parameter int SCALED_EVENTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = $clog2(NUM_EVENTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_TAKE,
		ST_PLACE,
		ST_FINISH
	} state_t;

	state_t           state_q;
	item_t            item_q;
	logic [31:0]      frame_q;
	logic [31:0]      now_q;
	logic [31:0]      when_q;
	logic             ds_q;
	logic             ptr_valid_q;
	logic [IDX_W-1:0] ptr_q;
	logic [31:0]      ptr_dl_q;
	logic             place_q;
	logic [IDX_W-1:0] cnt_q;
	logic             fired_q;
	logic [IDX_W-1:0] fid_q;
	logic [31:0]      fcyc_q;
	logic             done_q;
	result_t          result_q;

	cell_cmd_t              cmd;
	logic [NUM_EVENTS-1:0]  sched_vec;
	logic                   chain_valid [NUM_EVENTS+1];
	logic [IDX_W-1:0]       chain_idx   [NUM_EVENTS+1];
	logic [31:0]            chain_dl    [NUM_EVENTS+1];

	logic        id_ok;
	logic        id_scaled;
	logic        id_sched;
	logic        ptr_on_id;
	logic [31:0] fl_eff;
	logic [31:0] rel_when;

	// configuration port, one register, decoded where address bit 2 is low
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? frame_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FRAME_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			frame_q <= pwdata;
		end
	end

	// decode of the latched item
	assign id_ok     = ({28'd0, item_q.slot_id} < 32'(NUM_EVENTS));
	assign id_scaled = ({28'd0, item_q.slot_id} < 32'(SCALED_EVENTS));
	assign ptr_on_id = ptr_valid_q && (8'(ptr_q) == 8'(item_q.slot_id));
	assign fl_eff    = ds_q ? {frame_q[30:0], 1'b0} : frame_q;
	// scaled ids count their delay twice in double speed
	assign rel_when  = now_q + ((ds_q && id_scaled) ? {item_q.amount[30:0], 1'b0}
	                                                 : item_q.amount);

	always_comb begin
		id_sched = 1'b0;
		for (int i = 0; i < NUM_EVENTS; i++) begin
			if ((8'(item_q.slot_id) == 8'(i)) && sched_vec[i]) id_sched = 1'b1;
		end
	end

	// operation broadcast to the cell row
	always_comb begin
		cmd.op        = OP_NOP;
		cmd.id        = item_q.slot_id;
		cmd.value     = when_q;
		cmd.rel       = item_q.amount;
		cmd.set_rel   = (item_q.mode == MODE_SCHED_REL) || (item_q.mode == MODE_RESCHED);
		cmd.frame_len = fl_eff;
		case (state_q)
			ST_EXEC: begin
				case (item_q.mode)
					MODE_SCHED_REL, MODE_RESCHED, MODE_SCHED_ABS, MODE_REMOVE: begin
						if (id_ok && id_sched) cmd.op = OP_CLEAR;
					end
					MODE_CLEAR_GRP: cmd.op = OP_CLEAR_GROUP;
					MODE_SPEED: begin
						if (item_q.double_speed_request != ds_q) begin
							cmd.op = item_q.double_speed_request ? OP_SPEED_UP : OP_SPEED_DOWN;
						end
					end
					MODE_POP: begin
						if (ptr_valid_q) begin
							cmd.op = OP_CLEAR;
							cmd.id = 4'(ptr_q);
						end
					end
					MODE_FRAME: cmd.op = OP_FRAME;
					default: cmd.op = OP_NOP;
				endcase
			end
			ST_PLACE: cmd.op = OP_WRITE;
			default: cmd.op = OP_NOP;
		endcase
	end

	// row of slot cells; the running minimum enters empty at the head
	assign chain_valid[0] = 1'b0;
	assign chain_idx[0]   = '0;
	assign chain_dl[0]    = 32'd0;

	for (genvar g = 0; g < NUM_EVENTS; g++) begin : g_cell
		eds_cell #(
			.INDEX(g),
			.SCALED_EVENTS(SCALED_EVENTS),
			.IDX_W(IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.in_valid (chain_valid[g]),
			.in_idx   (chain_idx[g]),
			.in_dl    (chain_dl[g]),
			.out_valid(chain_valid[g+1]),
			.out_idx  (chain_idx[g+1]),
			.out_dl   (chain_dl[g+1]),
			.sched    (sched_vec[g])
		);
	end

	// sequencer: state, earliest pointer, time and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			now_q       <= 32'd0;
			when_q      <= 32'd0;
			ds_q        <= 1'b0;
			ptr_valid_q <= 1'b0;
			ptr_q       <= '0;
			ptr_dl_q    <= 32'd0;
			place_q     <= 1'b0;
			cnt_q       <= '0;
			fired_q     <= 1'b0;
			fid_q       <= '0;
			fcyc_q      <= 32'd0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q  <= item;
						place_q <= 1'b0;
						fired_q <= 1'b0;
						fid_q   <= '0;
						fcyc_q  <= 32'd0;
						cnt_q   <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (item_q.mode)
						MODE_SCHED_REL, MODE_RESCHED, MODE_SCHED_ABS: begin
							when_q <= (item_q.mode == MODE_SCHED_ABS) ? item_q.amount : rel_when;
							if (!id_ok) begin
								state_q <= ST_FINISH;
							end else if (id_sched && ptr_on_id) begin
								// displaced the earliest slot: rescan, then place
								ptr_valid_q <= 1'b0;
								place_q     <= 1'b1;
								state_q     <= ST_SCAN;
							end else begin
								state_q <= ST_PLACE;
							end
						end
						MODE_REMOVE: begin
							if (id_ok && id_sched && ptr_on_id) begin
								ptr_valid_q <= 1'b0;
								state_q     <= ST_SCAN;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						MODE_CLEAR_GRP: state_q <= ST_SCAN;
						MODE_SPEED: begin
							ds_q    <= item_q.double_speed_request;
							state_q <= ST_SCAN;
						end
						MODE_ADVANCE: begin
							now_q   <= now_q + item_q.amount;
							state_q <= ST_FINISH;
						end
						MODE_POP: begin
							if (ptr_valid_q) begin
								fired_q <= 1'b1;
								fid_q   <= ptr_q;
								fcyc_q  <= ptr_dl_q;
								if (ptr_dl_q > now_q) now_q <= ptr_dl_q;
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						MODE_FRAME: begin
							now_q   <= now_q - fl_eff;
							state_q <= ST_SCAN;
						end
						default: state_q <= ST_FINISH;
					endcase
				end
				ST_SCAN: begin
					// one cell per cycle; the tail register holds the answer after the last
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(NUM_EVENTS - 1)) state_q <= ST_TAKE;
				end
				ST_TAKE: begin
					ptr_valid_q <= chain_valid[NUM_EVENTS];
					ptr_q       <= chain_valid[NUM_EVENTS] ? chain_idx[NUM_EVENTS] : '0;
					ptr_dl_q    <= chain_dl[NUM_EVENTS];
					state_q     <= place_q ? ST_PLACE : ST_FINISH;
				end
				ST_PLACE: begin
					// pointer moves only on a strictly earlier deadline
					if (!ptr_valid_q || (when_q < ptr_dl_q)) begin
						ptr_valid_q <= 1'b1;
						ptr_q       <= IDX_W'(item_q.slot_id);
						ptr_dl_q    <= when_q;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					result_q.event_valid  <= fired_q;
					result_q.fired_id     <= 4'(fid_q);
					result_q.fired_cycle  <= fcyc_q;
					result_q.current_time <= now_q;
					result_q.any_pending  <= |sched_vec;
					result_q.frame_over   <= (now_q >= fl_eff) &&
					                         (!ptr_valid_q || (ptr_dl_q > fl_eff));
					done_q                <= 1'b1;
					state_q               <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

### tb/event_deadline_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_deadline_scheduler_checker
// predicts and checks every result of the event deadline scheduler
// ----------------------------------------------------------------------------
// Watches the command channel, the result strobe and the APB-style port. Each
// accepted item runs through a slot-level copy of the scheduler and its
// expected result is queued; each strobed result is compared field by field
// with the oldest queued one. Register reads are checked against the copy of
// frame_length. The failure count goes back to the test top.
// ----------------------------------------------------------------------------
module event_deadline_scheduler_checker import eds_pkg::*; #(
	parameter int NUM_EVENTS = 12,
	parameter int SCALED_EVENTS = 4,
	parameter logic [2:0] FRAME_LENGTH_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        done,
	input  result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatches,
	output int          awaited,
	output int          results_seen,
	output int          events_fired
);

	logic [31:0] slot_due [NUM_EVENTS];
	logic [31:0] slot_delay [NUM_EVENTS];
	logic        slot_armed [NUM_EVENTS];
	logic [31:0] clock_now;
	logic [31:0] frame_len_cfg;
	int          head_id;
	logic        head_ok;
	logic        fast_mode;
	result_t     due_results[$];

	function automatic logic [31:0] frame_span();
		logic [31:0] span;
		span = fast_mode ? frame_len_cfg << 1 : frame_len_cfg;
		return span;
	endfunction

	// lowest id wins on equal deadlines
	function automatic void find_head();
		head_ok = 1'b0;
		head_id = 0;
		for (int i = 0; i < NUM_EVENTS; i++)
			if (slot_armed[i] && (!head_ok || slot_due[i] < slot_due[head_id])) begin
				head_ok = 1'b1;
				head_id = i;
			end
	endfunction

	function automatic void unarm_slot(int id);
		slot_armed[id] = 1'b0;
		if (head_ok && head_id == id)
			find_head();
	endfunction

	function automatic void arm_slot(int id, logic [31:0] when);
		if (slot_armed[id])
			unarm_slot(id);
		slot_due[id] = when;
		slot_armed[id] = 1'b1;
		if (!head_ok || when < slot_due[head_id]) begin
			head_ok = 1'b1;
			head_id = id;
		end
	endfunction

	function automatic void arm_relative(int id, logic [31:0] delay);
		logic [31:0] span;
		span = (fast_mode && id < SCALED_EVENTS) ? delay << 1 : delay;
		if (slot_armed[id])
			unarm_slot(id);
		slot_delay[id] = delay;
		arm_slot(id, clock_now + span);
	endfunction

	function automatic result_t apply_command(item_t cmd);
		result_t     r;
		logic [31:0] span;
		logic        id_ok;
		int          id;
		r = '0;
		id = int'(cmd.slot_id);
		id_ok = id < NUM_EVENTS;
		case (cmd.mode)
			MODE_SCHED_REL, MODE_RESCHED: if (id_ok) arm_relative(id, cmd.amount);
			MODE_SCHED_ABS: if (id_ok) arm_slot(id, cmd.amount);
			MODE_REMOVE: if (id_ok) unarm_slot(id);
			MODE_CLEAR_GRP: begin
				for (int i = 0; i < SCALED_EVENTS && i < NUM_EVENTS; i++)
					slot_armed[i] = 1'b0;
				find_head();
			end
			MODE_SPEED: begin
				// scaled slots stretch or shrink by their own delay
				if (cmd.double_speed_request != fast_mode)
					for (int i = 0; i < SCALED_EVENTS && i < NUM_EVENTS; i++)
						if (slot_armed[i])
							slot_due[i] = cmd.double_speed_request ?
								slot_due[i] + slot_delay[i] : slot_due[i] - slot_delay[i];
				fast_mode = cmd.double_speed_request;
				find_head();
			end
			MODE_ADVANCE: clock_now = clock_now + cmd.amount;
			MODE_POP: begin
				if (head_ok) begin
					r.event_valid = 1'b1;
					r.fired_id = 4'(head_id);
					r.fired_cycle = slot_due[head_id];
					if (slot_due[head_id] > clock_now)
						clock_now = slot_due[head_id];
					slot_armed[head_id] = 1'b0;
					find_head();
				end
			end
			MODE_FRAME: begin
				span = frame_span();
				clock_now = clock_now - span;
				for (int i = 0; i < NUM_EVENTS; i++)
					if (slot_armed[i] && slot_due[i] > span)
						slot_due[i] = slot_due[i] - span;
				find_head();
			end
			default: ;
		endcase
		r.current_time = clock_now;
		for (int i = 0; i < NUM_EVENTS; i++)
			if (slot_armed[i])
				r.any_pending = 1'b1;
		span = frame_span();
		r.frame_over = clock_now >= span && (!head_ok || slot_due[head_id] > span);
		return r;
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
	endfunction

	function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			flag_mismatch(what, want, got);
	endfunction

	function automatic void check_result();
		result_t want;
		results_seen++;
		if (due_results.size() == 0) begin
			flag_mismatch("result with no item outstanding", '0, result.current_time);
			return;
		end
		want = due_results.pop_front();
		if (want.event_valid)
			events_fired++;
		compare_field("event_valid", 32'(want.event_valid), 32'(result.event_valid));
		compare_field("fired_id", 32'(want.fired_id), 32'(result.fired_id));
		compare_field("fired_cycle", want.fired_cycle, result.fired_cycle);
		compare_field("current_time", want.current_time, result.current_time);
		compare_field("any_pending", 32'(want.any_pending), 32'(result.any_pending));
		compare_field("frame_over", 32'(want.frame_over), 32'(result.frame_over));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_EVENTS; i++) begin
				slot_due[i] = '0;
				slot_delay[i] = '0;
				slot_armed[i] = 1'b0;
			end
			clock_now = '0;
			frame_len_cfg = FRAME_RESET;
			head_id = 0;
			head_ok = 1'b0;
			fast_mode = 1'b0;
			due_results.delete();
			mismatches = 0;
			awaited = 0;
			results_seen = 0;
			events_fired = 0;
		end else begin
			// a strobe at the same edge as an accept belongs to the older item
			if (done)
				check_result();
			if (start && !busy)
				due_results.push_back(apply_command(item));
			if (psel && penable && pready && paddr == FRAME_LENGTH_ADDR) begin
				if (pwrite)
					frame_len_cfg = pwdata;
				else
					compare_field("frame_length readback", frame_len_cfg, prdata);
			end
			awaited = due_results.size();
		end
	end

endmodule

### tb/event_deadline_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_deadline_scheduler_unit_test
// directed and random regression of the event deadline scheduler
// ----------------------------------------------------------------------------
// Drives commands on the start/busy channel and frame_length over the APB-
// style port. A short directed list hits every mode, ties, out-of-range ids,
// speed changes and frame turnaround; then three random phases run under
// different frame lengths and sender idle rates. The checker beside the block
// predicts and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module event_deadline_scheduler_unit_test;
	import eds_pkg::*;

	localparam int NUM_EVENTS = 12;
	localparam int SCALED_EVENTS = 4;
	localparam logic [2:0] FRAME_LENGTH_ADDR = 3'd0;
	// drain time covers the longest command from accept to next accept, with margin
	localparam int DRAIN_CYCLES = NUM_EVENTS + 10;
	// ~2100 items plus sender gaps, taken many times over
	localparam int CYCLE_LIMIT = 800000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	item_t       item;
	logic        busy;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int awaited;
	int results_seen;
	int events_fired;

	int cycle_count = 0;
	int idle_pct = 0;
	int amount_span = 100;
	int ignored_count = 0;
	int mode_hits [16];

	event_deadline_scheduler_unit #(
		.NUM_EVENTS(NUM_EVENTS),
		.SCALED_EVENTS(SCALED_EVENTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	event_deadline_scheduler_checker #(
		.NUM_EVENTS(NUM_EVENTS),
		.SCALED_EVENTS(SCALED_EVENTS),
		.FRAME_LENGTH_ADDR(FRAME_LENGTH_ADDR)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.mismatches(mismatches),
		.awaited(awaited),
		.results_seen(results_seen),
		.events_fired(events_fired)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic item_t make_cmd(logic [3:0] mode, logic [3:0] id, logic [31:0] amount,
			logic req);
		item_t cmd;
		cmd.mode = mode;
		cmd.slot_id = id;
		cmd.amount = amount;
		cmd.double_speed_request = req;
		return cmd;
	endfunction

	// mostly small amounts around the current span, some corners, some full range
	function automatic logic [31:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, amount_span);
		if (r < 80)
			return $urandom_range(0, amount_span * 8);
		if (r < 90) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'h0000_0001;
				2: return 32'hFFFF_FFFE;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	// schedules and pops dominate so slots fill and drain, other modes mixed in
	function automatic item_t random_command(output bit effective);
		item_t cmd;
		int    r;
		r = $urandom_range(0, 99);
		cmd.slot_id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(NUM_EVENTS, 15)) :
			4'($urandom_range(0, NUM_EVENTS - 1));
		cmd.amount = pick_amount();
		cmd.double_speed_request = 1'($urandom_range(0, 1));
		if (r < 22)
			cmd.mode = MODE_SCHED_REL;
		else if (r < 30)
			cmd.mode = MODE_SCHED_ABS;
		else if (r < 38)
			cmd.mode = MODE_REMOVE;
		else if (r < 41)
			cmd.mode = MODE_CLEAR_GRP;
		else if (r < 49)
			cmd.mode = MODE_RESCHED;
		else if (r < 54)
			cmd.mode = MODE_SPEED;
		else if (r < 70)
			cmd.mode = MODE_ADVANCE;
		else if (r < 92)
			cmd.mode = MODE_POP;
		else if (r < 97)
			cmd.mode = MODE_FRAME;
		else
			cmd.mode = 4'($urandom_range(int'(MODE_FRAME) + 1, 15));
		// out-of-range ids on slot commands and unused modes do nothing
		effective = cmd.mode <= MODE_FRAME;
		if ((cmd.mode == MODE_SCHED_REL || cmd.mode == MODE_SCHED_ABS ||
				cmd.mode == MODE_REMOVE || cmd.mode == MODE_RESCHED) &&
				cmd.slot_id >= NUM_EVENTS)
			effective = 1'b0;
		return cmd;
	endfunction

	// one item through the start/busy handshake, with random gaps before it
	task automatic send_command(input item_t cmd);
		// now and then hold off until every result is back
		if ($urandom_range(0, 99) == 0) begin
			@(negedge clk);
			start = 1'b0;
			while (awaited != 0)
				@(negedge clk);
		end
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		item = cmd;
		do @(posedge clk); while (busy);
		mode_hits[cmd.mode]++;
	endtask

	// block idle: nothing in flight and the scan given time to finish
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (awaited != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// write frame_length, then read it back for the checker
	task automatic program_frame_length(input logic [31:0] value);
		for (int pass = 0; pass < 2; pass++) begin
			@(negedge clk);
			psel = 1'b1;
			penable = 1'b0;
			pwrite = (pass == 0);
			paddr = FRAME_LENGTH_ADDR;
			pwdata = value;
			@(negedge clk);
			penable = 1'b1;
			do @(posedge clk); while (!pready);
			@(negedge clk);
			psel = 1'b0;
			penable = 1'b0;
			pwrite = 1'b0;
		end
	endtask

	task automatic run_directed();
		item_t script[$];
		// relative first on every scaled id so a later speed change never
		// reads a delay that was never written
		script.push_back(make_cmd(MODE_SCHED_REL, 4'd0, 32'd10, 1'b0));
		script.push_back(make_cmd(MODE_SCHED_REL, 4'd1, 32'd20, 1'b0));
		script.push_back(make_cmd(MODE_SCHED_REL, 4'd2, 32'd0, 1'b0));
		script.push_back(make_cmd(MODE_SCHED_REL, 4'd3, 32'd30, 1'b1));
		// highest id, then an absolute deadline at the top of the range
		script.push_back(make_cmd(MODE_SCHED_ABS, 4'd11, 32'd5, 1'b0));
		script.push_back(make_cmd(MODE_SCHED_ABS, 4'd5, 32'hFFFF_FFFF, 1'b1));
		// out-of-range ids are no-ops
		script.push_back(make_cmd(MODE_SCHED_REL, 4'd15, 32'd7, 1'b0));
		script.push_back(make_cmd(MODE_REMOVE, 4'd12, 32'd0, 1'b0));
		// scheduling an armed slot again, then a tie with it
		script.push_back(make_cmd(MODE_SCHED_REL, 4'd1, 32'd20, 1'b0));
		script.push_back(make_cmd(MODE_RESCHED, 4'd4, 32'd20, 1'b0));
		// into double speed, then the same speed again
		script.push_back(make_cmd(MODE_SPEED, 4'd0, 32'd0, 1'b1));
		script.push_back(make_cmd(MODE_SPEED, 4'd9, 32'hFFFF_FFFF, 1'b1));
		script.push_back(make_cmd(MODE_SCHED_REL, 4'd0, 32'd3, 1'b0));
		script.push_back(make_cmd(MODE_POP, 4'd0, 32'd0, 1'b0));
		script.push_back(make_cmd(MODE_POP, 4'd0, 32'd0, 1'b0));
		script.push_back(make_cmd(MODE_REMOVE, 4'd4, 32'd0, 1'b0));
		script.push_back(make_cmd(MODE_CLEAR_GRP, 4'd0, 32'd0, 1'b0));
		script.push_back(make_cmd(MODE_ADVANCE, 4'd0, 32'd150, 1'b0));
		// time below the doubled frame wraps on turnaround
		script.push_back(make_cmd(MODE_FRAME, 4'd0, 32'd0, 1'b0));
		script.push_back(make_cmd(MODE_ADVANCE, 4'd0, 32'hFFFF_FFFF, 1'b0));
		script.push_back(make_cmd(MODE_SPEED, 4'd0, 32'd0, 1'b0));
		// empty the row, then pop with nothing pending
		script.push_back(make_cmd(MODE_REMOVE, 4'd5, 32'd0, 1'b0));
		script.push_back(make_cmd(MODE_POP, 4'd0, 32'd0, 1'b0));
		// unused modes
		script.push_back(make_cmd(4'd9, 4'd0, 32'd0, 1'b0));
		script.push_back(make_cmd(4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1));
		foreach (script[i])
			send_command(script[i]);
	endtask

	task automatic run_random(input logic [31:0] frame_len, input int sender_idle,
			input int span, input int target);
		item_t cmd;
		bit    effective;
		int    counted;
		settle();
		program_frame_length(frame_len);
		idle_pct = sender_idle;
		amount_span = span;
		counted = 0;
		while (counted < target) begin
			cmd = random_command(effective);
			send_command(cmd);
			if (effective)
				counted++;
			else
				ignored_count++;
		end
	endtask

	initial begin
		int frame_pick;
		// every input known from time zero, reset asserted first and released on a falling edge
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short frame so turnaround and frame_over show up early
		program_frame_length(32'd100);
		run_directed();

		// sender idles sometimes, then often, then never; frame length mid, one, max
		frame_pick = $urandom_range(50, 2000);
		run_random(frame_pick, 17, frame_pick, 700);
		run_random(32'd1, 77, 8, 650);
		run_random(32'hFFFF_FFFF, 0, 500, 650);

		// back to the reset value, then drain
		settle();
		program_frame_length(FRAME_RESET);
		settle();

		$display("run covered %0d items (%0d ignored) over frame lengths 100, %0d, 1 and max",
			results_seen, ignored_count, frame_pick);
		$display("%0d pops fired, %0d frame turnarounds, %0d speed commands, %0d advances",
			events_fired, mode_hits[MODE_FRAME], mode_hits[MODE_SPEED],
			mode_hits[MODE_ADVANCE]);
		if (mismatches == 0 && awaited == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
